### rtl/streaming_edge_community_clustering_macros.svh
// Assertion macros for the streaming edge community clustering block.
// Expects signals named clk and rst in the scope of use.
`ifndef STREAMING_EDGE_COMMUNITY_CLUSTERING_MACROS_SVH
`define STREAMING_EDGE_COMMUNITY_CLUSTERING_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sce: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SCE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sce: next-cycle check failed");

`endif

### rtl/sce_pkg.sv
// Shared constants, types and helpers for the edge community clustering block.
// No dependencies.
`timescale 1ns / 1ps

package sce_pkg;

  localparam int VERTEX_COUNT = 65536;
  localparam int VERTEX_BITS  = $clog2(VERTEX_COUNT);
  localparam int LABEL_W      = VERTEX_BITS + 1;
  localparam int VOL_DEPTH    = VERTEX_COUNT + 1;
  localparam int VOL_W        = 32;
  localparam int DEG_W        = 24;
  localparam int MOVED_W      = 2;

  localparam logic [MOVED_W-1:0] MOVED_NONE = 2'd0;
  localparam logic [MOVED_W-1:0] MOVED_U    = 2'd1;
  localparam logic [MOVED_W-1:0] MOVED_V    = 2'd2;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] vertex_u;
    logic [VERTEX_BITS-1:0] vertex_v;
    logic [DEG_W-1:0]       degree_u;
    logic [DEG_W-1:0]       degree_v;
  } edge_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label_u;
    logic [LABEL_W-1:0] label_v;
    logic [MOVED_W-1:0] moved;
  } result_t;

  typedef struct packed {
    logic take;      // core takes the buffered edge this cycle
    logic res_load;  // core hands a result to the output register
    logic clearing;  // post-reset memory clear in progress
  } core_status_t;

  // Fresh labels past the last slot fold onto slot zero.
  function automatic logic [LABEL_W-1:0] label_slot(input logic [LABEL_W-1:0] lab);
    return (lab <= LABEL_W'(VERTEX_COUNT)) ? lab : '0;
  endfunction

endpackage

### rtl/sce_ram.sv
// Generic simple dual-port RAM: one write and one registered read per cycle.
// A read of the address written in the same cycle returns the new data.
`timescale 1ns / 1ps

module sce_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/sce_core.sv
// Edge sequencer: label and volume memories, fresh-label allocation, move decision.
// Depends on sce_pkg and sce_ram.
`timescale 1ns / 1ps

module sce_core import sce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  edge_t             item,
  input  logic [VOL_W-1:0]  max_volume,
  input  logic              out_free,
  output result_t           result,
  output core_status_t      status
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LU   = 3'd1;
  localparam logic [2:0] ST_LV   = 3'd2;
  localparam logic [2:0] ST_VOL  = 3'd3;
  localparam logic [2:0] ST_DEC  = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;

  localparam int SUM_W = VOL_W + 2;
  localparam int CHK_W = VOL_W + 1;

  logic [2:0]         state;
  logic [2:0]         state_next;
  edge_t              cur;
  logic [LABEL_W-1:0] next_label;
  logic [LABEL_W-1:0] cu;
  logic [LABEL_W-1:0] cv;
  logic               nu;
  logic               nv;
  logic [VOL_W-1:0]   vcu;
  logic [VOL_W-1:0]   vol_u;
  logic [VOL_W-1:0]   vol_v;
  logic [LABEL_W-1:0] fin_u;
  logic [LABEL_W-1:0] fin_v;
  logic [VOL_W-1:0]   new_v;
  logic [MOVED_W-1:0] moved;
  logic               clearing;
  logic [LABEL_W-1:0] clr_cnt;

  logic                   start;
  logic                   res_load;

  logic                   l_we;
  logic [VERTEX_BITS-1:0] l_waddr;
  logic [LABEL_W-1:0]     l_wdata;
  logic [VERTEX_BITS-1:0] l_raddr;
  logic [LABEL_W-1:0]     l_rdata;
  logic                   v_we;
  logic [LABEL_W-1:0]     v_waddr;
  logic [VOL_W-1:0]       v_wdata;
  logic [LABEL_W-1:0]     v_raddr;
  logic [VOL_W-1:0]       v_rdata;

  // First endpoint lookup
  logic               nu_c;
  logic [LABEL_W-1:0] cu_c;
  logic [LABEL_W-1:0] nl_u;
  // Second endpoint lookup
  logic [LABEL_W-1:0] lv_eff;
  logic               nv_c;
  logic [LABEL_W-1:0] cv_c;
  logic [LABEL_W-1:0] nl_v;
  // Volume update after allocation
  logic               same;
  logic [SUM_W-1:0]   sum_u;
  logic [SUM_W-1:0]   sum_v;
  // Move decision
  logic               may_move;
  logic               chk_u;
  logic               chk_v;
  logic               mv_u;
  logic               mv_v;
  logic [VOL_W-1:0]   du_w;
  logic [VOL_W-1:0]   dv_w;
  logic [VOL_W-1:0]   new_u_c;
  logic [VOL_W-1:0]   new_v_c;
  logic [LABEL_W-1:0] fin_u_c;
  logic [LABEL_W-1:0] fin_v_c;
  logic [MOVED_W-1:0] moved_c;

  sce_ram #(.WIDTH(LABEL_W), .DEPTH(VERTEX_COUNT), .ADDR_W(VERTEX_BITS)) u_label_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  sce_ram #(.WIDTH(VOL_W), .DEPTH(VOL_DEPTH), .ADDR_W(LABEL_W)) u_volume_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  assign res_load = (state == ST_WB) && out_free;
  assign start    = !clearing && item_valid && ((state == ST_IDLE) || res_load);

  always_comb begin
    nu_c = (l_rdata == '0);
    cu_c = nu_c ? label_slot(next_label) : l_rdata;
    nl_u = (nu_c && next_label <= LABEL_W'(VERTEX_COUNT)) ? next_label + 1'b1 : next_label;

    // A self loop sees the label just given to the first endpoint.
    lv_eff = (cur.vertex_v == cur.vertex_u) ? cu : l_rdata;
    nv_c   = (lv_eff == '0);
    cv_c   = nv_c ? label_slot(next_label) : lv_eff;
    nl_v   = (nv_c && next_label <= LABEL_W'(VERTEX_COUNT)) ? next_label + 1'b1 : next_label;

    same  = (cu == cv);
    sum_u = {2'b00, vcu}
          + (nu ? {{(SUM_W-DEG_W){1'b0}}, cur.degree_u} : '0)
          + ((nv && same) ? {{(SUM_W-DEG_W){1'b0}}, cur.degree_v} : '0);
    sum_v = {2'b00, v_rdata}
          + (nv ? {{(SUM_W-DEG_W){1'b0}}, cur.degree_v} : '0)
          + ((nu && same) ? {{(SUM_W-DEG_W){1'b0}}, cur.degree_u} : '0);

    du_w     = {{(VOL_W-DEG_W){1'b0}}, cur.degree_u};
    dv_w     = {{(VOL_W-DEG_W){1'b0}}, cur.degree_v};
    may_move = (cu != cv) && (vol_u <= max_volume) && (vol_v <= max_volume);
    chk_u    = ({1'b0, vol_v} + {1'b0, du_w}) <= {1'b0, max_volume};
    chk_v    = ({1'b0, vol_u} + {1'b0, dv_w}) <= {1'b0, max_volume};
    mv_u     = may_move && (vol_u <= vol_v) && chk_u;
    mv_v     = may_move && (vol_u > vol_v) && chk_v;

    // The checks above bound the receiving sum, so no saturation is needed there.
    new_u_c = vol_u;
    new_v_c = vol_v;
    fin_u_c = cu;
    fin_v_c = cv;
    moved_c = MOVED_NONE;
    if (mv_u) begin
      new_u_c = (vol_u >= du_w) ? vol_u - du_w : '0;
      new_v_c = vol_v + du_w;
      fin_u_c = cv;
      moved_c = MOVED_U;
    end else if (mv_v) begin
      new_v_c = (vol_v >= dv_w) ? vol_v - dv_w : '0;
      new_u_c = vol_u + dv_w;
      fin_v_c = cu;
      moved_c = MOVED_V;
    end
  end

  // Memory port steering
  always_comb begin
    l_raddr = start ? item.vertex_u : cur.vertex_v;
    v_raddr = (state == ST_LU) ? cu_c : cv_c;

    l_we    = 1'b0;
    l_waddr = cur.vertex_u;
    l_wdata = fin_u_c;
    v_we    = 1'b0;
    v_waddr = cu;
    v_wdata = new_u_c;
    if (clearing) begin
      l_we    = !clr_cnt[VERTEX_BITS];
      l_waddr = clr_cnt[VERTEX_BITS-1:0];
      l_wdata = '0;
      v_we    = 1'b1;
      v_waddr = clr_cnt;
      v_wdata = '0;
    end else if (state == ST_DEC) begin
      l_we = 1'b1;
      v_we = 1'b1;
    end else if (state == ST_WB) begin
      l_we    = 1'b1;
      l_waddr = cur.vertex_v;
      l_wdata = fin_v;
      v_we    = 1'b1;
      v_waddr = cv;
      v_wdata = new_v;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_LU;
      ST_LU:   state_next = ST_LV;
      ST_LV:   state_next = ST_VOL;
      ST_VOL:  state_next = ST_DEC;
      ST_DEC:  state_next = ST_WB;
      ST_WB: begin
        if (res_load) begin
          state_next = start ? ST_LU : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      next_label <= LABEL_W'(1);
      clearing   <= 1'b1;
      clr_cnt    <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == LABEL_W'(VOL_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (state == ST_LU) begin
        next_label <= nl_u;
      end else if (state == ST_LV) begin
        next_label <= nl_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= item;
    end
    if (state == ST_LU) begin
      cu <= cu_c;
      nu <= nu_c;
    end
    if (state == ST_LV) begin
      cv  <= cv_c;
      nv  <= nv_c;
      vcu <= v_rdata;
    end
    if (state == ST_VOL) begin
      vol_u <= (|sum_u[SUM_W-1:VOL_W]) ? '1 : sum_u[VOL_W-1:0];
      vol_v <= (|sum_v[SUM_W-1:VOL_W]) ? '1 : sum_v[VOL_W-1:0];
    end
    if (state == ST_DEC) begin
      fin_u <= fin_u_c;
      fin_v <= fin_v_c;
      new_v <= new_v_c;
      moved <= moved_c;
    end
  end

  assign result.label_u  = fin_u;
  assign result.label_v  = fin_v;
  assign result.moved    = moved;
  assign status.take     = start;
  assign status.res_load = res_load;
  assign status.clearing = clearing;

endmodule

### rtl/streaming_edge_community_clustering.sv
// Streaming edge community clustering (streaming graph clustering, top level).
// Input channel: in_valid / in_stall with vertex_u, vertex_v, degree_u, degree_v.
// Output channel: out_valid / out_stall with label_u, label_v, moved; one result
// per edge, in edge order. A transfer happens when valid is high and stall low.
// Config: cfg_wr_en / cfg_wr_data write max_volume (reset value all ones).
// An accepted edge waits in a one-entry input buffer, so the next edge is taken
// while the current one is still being worked on. A result reaches out_valid through
// the input buffer, the sequencer's label, volume, decision and write-back steps and the
// output register. The sequencer handles one edge at a time: it reads the first label,
// the second label and the two community volumes, then writes two label and two volume
// entries through the single write port of each memory; the last write overlaps the
// next edge's first label read.
// After reset a clearing pass zeroes both memories, one entry a cycle; in_stall
// stays high during it. next_label restarts at one.
// While out_stall holds a result, the sequencer waits in its write-back step and
// the input buffer fills and then stalls.
`timescale 1ns / 1ps

module streaming_edge_community_clustering import sce_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VERTEX_BITS-1:0] vertex_u,
  input  logic [VERTEX_BITS-1:0] vertex_v,
  input  logic [DEG_W-1:0]       degree_u,
  input  logic [DEG_W-1:0]       degree_v,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LABEL_W-1:0]     label_u,
  output logic [LABEL_W-1:0]     label_v,
  output logic [MOVED_W-1:0]     moved,
  input  logic                   cfg_wr_en,
  input  logic [VOL_W-1:0]       cfg_wr_data
);

`include "streaming_edge_community_clustering_macros.svh"

  logic [VOL_W-1:0] max_volume;
  edge_t            in_buf;
  logic             buf_valid;
  logic             out_free;
  result_t          result;
  core_status_t     status;

  assign in_stall = buf_valid || status.clearing;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_volume <= '1;
    end else if (cfg_wr_en) begin
      max_volume <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      buf_valid <= 1'b1;
    end else if (status.take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_buf.vertex_u <= vertex_u;
      in_buf.vertex_v <= vertex_v;
      in_buf.degree_u <= degree_u;
      in_buf.degree_v <= degree_v;
    end
  end

  sce_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (buf_valid),
    .item       (in_buf),
    .max_volume (max_volume),
    .out_free   (out_free),
    .result     (result),
    .status     (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.res_load) begin
      label_u <= result.label_u;
      label_v <= result.label_v;
      moved   <= result.moved;
    end
  end

  `SCE_ASSERT_IMP(a_load_into_free_slot, status.res_load, !out_valid || !out_stall)
  `SCE_ASSERT_IMP(a_take_needs_buffer, status.take, buf_valid && !status.clearing)
  `SCE_ASSERT_IMP(a_move_joins_labels, out_valid && moved != MOVED_NONE, label_u == label_v)
  `SCE_ASSERT_NXT(a_take_spacing, status.take, !status.take)

endmodule

### dv/tb_streaming_edge_community_clustering.sv
// Self-checking bench for streaming_edge_community_clustering: directed and random
// edge streams, with labels and community volumes tracked in the bench.
// Depends on sce_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_streaming_edge_community_clustering import sce_pkg::*;;

  localparam int WATCHDOG_LIMIT = 300000;  // longer than the clearing pass after reset
  localparam int LONG_HOLD      = 400;
  localparam int HUB_VERTEX     = 39999;
  localparam int CHAIN_FIRST    = 40000;
  localparam int CHAIN_LEN      = 270;
  localparam logic [VOL_W-1:0] VOL_ALL_ONES = '1;
  localparam logic [DEG_W-1:0] DEG_ALL_ONES = '1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [VERTEX_BITS-1:0] vertex_u;
  logic [VERTEX_BITS-1:0] vertex_v;
  logic [DEG_W-1:0]       degree_u;
  logic [DEG_W-1:0]       degree_v;
  logic                   out_valid;
  logic                   out_stall = 1'b1;
  logic [LABEL_W-1:0]     label_u;
  logic [LABEL_W-1:0]     label_v;
  logic [MOVED_W-1:0]     moved;
  logic                   cfg_wr_en = 1'b0;
  logic [VOL_W-1:0]       cfg_wr_data = '0;

  edge_t on_bus = '0;

  assign vertex_u = on_bus.vertex_u;
  assign vertex_v = on_bus.vertex_v;
  assign degree_u = on_bus.degree_u;
  assign degree_v = on_bus.degree_v;

  streaming_edge_community_clustering i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .vertex_u   (vertex_u),
    .vertex_v   (vertex_v),
    .degree_u   (degree_u),
    .degree_v   (degree_v),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .label_u    (label_u),
    .label_v    (label_v),
    .moved      (moved),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Clustering state as the bench sees it
  bit [LABEL_W-1:0] vtx_comm [VERTEX_COUNT];
  bit [VOL_W-1:0]   comm_vol [VOL_DEPTH];
  bit [LABEL_W-1:0] fresh_label = LABEL_W'(1);
  bit [VOL_W-1:0]   max_vol = VOL_ALL_ONES;

  edge_t   edges_pending[$];
  result_t labels_due[$];

  int gap_max = 0;
  int stall_pct = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_run = 0;
  bit rx_stall_pick;
  int mismatch_count = 0;
  int idle_cycles = 0;
  edge_t   next_edge;
  result_t due;

  function automatic bit [LABEL_W-1:0] comm_slot(bit [LABEL_W-1:0] lab);
    return (lab <= LABEL_W'(VERTEX_COUNT)) ? lab : '0;
  endfunction

  function automatic bit [VOL_W-1:0] vol_plus(bit [VOL_W-1:0] a, bit [DEG_W-1:0] b);
    bit [VOL_W:0] s;
    s = {1'b0, a} + b;
    return s[VOL_W] ? VOL_ALL_ONES : s[VOL_W-1:0];
  endfunction

  function automatic bit [VOL_W-1:0] vol_minus(bit [VOL_W-1:0] a, bit [DEG_W-1:0] b);
    return (a >= b) ? a - b : '0;
  endfunction

  // Give an unlabeled vertex the next fresh community, then return its community.
  function automatic bit [LABEL_W-1:0] label_or_claim(bit [VERTEX_BITS-1:0] vtx,
                                                      bit [DEG_W-1:0] deg);
    bit [LABEL_W-1:0] lab;
    if (vtx_comm[vtx] == '0) begin
      lab = comm_slot(fresh_label);
      vtx_comm[vtx] = lab;
      comm_vol[lab] = vol_plus(comm_vol[lab], deg);
      if (fresh_label <= LABEL_W'(VERTEX_COUNT)) fresh_label++;
    end
    return comm_slot(vtx_comm[vtx]);
  endfunction

  function automatic result_t cluster_edge(edge_t e);
    bit [LABEL_W-1:0] cu, cv;
    bit [VOL_W-1:0]   vu, vv;
    result_t          r;
    cu = label_or_claim(e.vertex_u, e.degree_u);
    cv = label_or_claim(e.vertex_v, e.degree_v);
    r.moved = MOVED_NONE;
    if (cu != cv) begin
      vu = comm_vol[cu];
      vv = comm_vol[cv];
      if (vu <= max_vol && vv <= max_vol) begin
        // the smaller side joins; the room check is done in 33 bits
        if (vu <= vv) begin
          if ({1'b0, vv} + e.degree_u <= {1'b0, max_vol}) begin
            comm_vol[cu] = vol_minus(vu, e.degree_u);
            comm_vol[cv] = vol_plus(vv, e.degree_u);
            vtx_comm[e.vertex_u] = cv;
            cu = cv;
            r.moved = MOVED_U;
          end
        end else if ({1'b0, vu} + e.degree_v <= {1'b0, max_vol}) begin
          comm_vol[cv] = vol_minus(vv, e.degree_v);
          comm_vol[cu] = vol_plus(vu, e.degree_v);
          vtx_comm[e.vertex_v] = cu;
          cv = cu;
          r.moved = MOVED_V;
        end
      end
    end
    r.label_u = cu;
    r.label_v = cv;
    return r;
  endfunction

  function automatic bit [DEG_W-1:0] random_degree();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return '0;
    if (pick < 60) return DEG_W'($urandom_range(1, 8));
    if (pick < 80) return DEG_W'($urandom_range(1, 1000));
    if (pick < 88) return DEG_ALL_ONES;
    return DEG_W'($urandom_range(0, 24'hFFFFFF));
  endfunction

  // Mostly edges inside a small vertex window so communities form and merge.
  function automatic edge_t random_edge(int base, int span);
    edge_t e;
    if ($urandom_range(0, 9) == 0) begin
      e.vertex_u = VERTEX_BITS'($urandom_range(0, 16'hFFFF));
      e.vertex_v = VERTEX_BITS'($urandom_range(0, 16'hFFFF));
      e.degree_u = DEG_W'($urandom_range(0, 24'hFFFFFF));
      e.degree_v = DEG_W'($urandom_range(0, 24'hFFFFFF));
    end else begin
      e.vertex_u = VERTEX_BITS'(base + $urandom_range(0, span - 1));
      e.vertex_v = ($urandom_range(0, 19) == 0) ? e.vertex_u
                                                : VERTEX_BITS'(base + $urandom_range(0, span - 1));
      e.degree_u = random_degree();
      e.degree_v = random_degree();
    end
    return e;
  endfunction

  task automatic push_edge(int u, int v, int du, int dv);
    edge_t e;
    e.vertex_u = VERTEX_BITS'(u);
    e.vertex_v = VERTEX_BITS'(v);
    e.degree_u = DEG_W'(du);
    e.degree_v = DEG_W'(dv);
    edges_pending.push_back(e);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    while (edges_pending.size() != 0 || in_valid || labels_due.size() != 0)
      @(negedge clk);
  endtask

  // Write max_volume once the block has gone quiet.
  task automatic set_limit(bit [VOL_W-1:0] limit);
    wait_drain();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_vol = limit;
    @(negedge clk);
  endtask

  task automatic random_phase(bit [VOL_W-1:0] limit, int count, int span, int gaps,
                              int stall_share);
    int base;
    set_limit(limit);
    gap_max   = gaps;
    stall_pct = stall_share;
    base = $urandom_range(0, 16'hFFFF);
    repeat (count) edges_pending.push_back(random_edge(base, span));
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) labels_due.push_back(cluster_edge(on_bus));
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (edges_pending.size() != 0) begin
        next_edge = edges_pending.pop_front();
        in_valid <= 1'b1;
        on_bus   <= next_edge;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall runs, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD - 1;
      rx_run    = 0;
      out_stall <= 1'b1;
    end else if (rx_run > 0) begin
      rx_run--;
    end else begin
      rx_stall_pick = ($urandom_range(0, 99) < stall_pct);
      rx_run = rx_stall_pick ? $urandom_range(0, 6) : $urandom_range(0, 15);
      out_stall <= rx_stall_pick;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (labels_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: label_u=%0d label_v=%0d moved=%0d",
                   label_u, label_v, moved);
      end else begin
        due = labels_due.pop_front();
        if (label_u !== due.label_u || label_v !== due.label_v || moved !== due.moved) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected label_u=%0d label_v=%0d moved=%0d, got %0d %0d %0d",
                     due.label_u, due.label_v, due.moved, label_u, label_v, moved);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_limit(VOL_ALL_ONES);
    gap_max   = 3;
    stall_pct = 25;
    push_edge(0, 65535, 0, 24'hFFFFFF);            // both fresh, first endpoint moves
    push_edge(65535, 0, 24'hFFFFFF, 0);            // same community
    push_edge(5, 5, 7, 7);                         // self loop on a fresh vertex
    push_edge(6, 7, 3, 9);
    push_edge(8, 7, 20, 1);                        // larger first side: second joins
    push_edge(9, 10, 4, 4);                        // equal volumes: first joins
    push_edge(14, 15, 1, 2);
    push_edge(14, 16, 500, 600);                   // leaving degree exceeds volume
    push_edge(17, 18, 0, 0);
    push_edge(18, 17, 0, 0);
    push_edge(16'hAAAA, 16'h5555, 24'hAAAAAA, 24'h555555);
    push_edge(16'h5555, 16'hAAAA, 24'h555555, 24'hAAAAAA);
    push_edge(19, 20, 24'hFFFFFF, 24'hFFFFFE);
    push_edge(20, 19, 1, 1);
    push_edge(21, 8, 24'h800000, 24'h000001);
    push_edge(7, 21, 24'h000001, 24'h800000);
    push_edge(6, 9, 2, 2);
    push_edge(10, 14, 3, 300);
    push_edge(0, 5, 24'hFFFFFF, 7);
    push_edge(65535, 65535, 0, 0);

    // Grow one community with full-degree vertices until the room check overflows 32 bits.
    set_limit(VOL_ALL_ONES);
    gap_max   = 0;
    stall_pct = 0;
    for (int i = 0; i < CHAIN_LEN; i++)
      push_edge(CHAIN_FIRST + i, HUB_VERTEX, DEG_ALL_ONES, $urandom_range(0, 24'hFFFFFF));

    random_phase('0, 150, 64, 4, 30);

    // Block fills and stalls its input behind a long receiver hold-off.
    random_phase(40, 200, 48, 0, 20);
    hold_token++;

    random_phase(1000, 200, 200, 6, 50);
    random_phase(32'h00FF_FFFF, 150, 500, 2, 10);
    random_phase($urandom, 150, 100, 5, 40);
    random_phase(VOL_ALL_ONES - 1, 150, 1000, 0, 0);
    random_phase(VOL_ALL_ONES, 150, 64, 8, 60);

    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && labels_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
